>>> rtl/hpid_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hpid_pkg;

   // item and register widths
   localparam int ANGLE_W = 17;
   localparam int DIFF_W = ANGLE_W + 1;
   localparam int ERR_W = 16;
   localparam int DE_W = ERR_W + 1;
   localparam int PER_W = 20;
   localparam int GAIN_W = 24;
   localparam int VEL_W = 16;
   localparam int OUT_W = VEL_W + 1;
   localparam int INTEG_W = 48;
   localparam int CSR_IDX_W = 2;
   localparam int REQ_W = 56;
   localparam int RSP_W = 24;

   // shared multiplier and accumulators
   localparam int MUL_W = 24;
   localparam int PROD_W = 2 * MUL_W;
   localparam int ACC_W = PROD_W + MUL_W;
   localparam int TOT_W = 62;
   localparam int FRAC_BITS = 23;
   localparam int DMAG_W = TOT_W - FRAC_BITS;

   // radix-4 restoring divider
   localparam int DIV_W = ACC_W;
   localparam int DIV_BITS = 2;
   localparam int DIV_STEPS = DIV_W / DIV_BITS;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

   // heading wrap
   localparam int WRAP_STEPS = 3;
   localparam logic signed [DIFF_W-1:0] HALF_TURN = 18'sd23040;
   localparam logic signed [DIFF_W-1:0] NEG_HALF_TURN = -18'sd23040;
   localparam logic signed [DIFF_W-1:0] FULL_TURN = 18'sd46080;

   localparam logic [PER_W-1:0] US_PER_S = 20'd1000000;
   localparam logic [PER_W-1:0] DEFAULT_PERIOD_US = 20'd33330;

   localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
   localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KP   = 2'd0,
      CSR_KI   = 2'd1,
      CSR_KD   = 2'd2,
      CSR_VMAX = 2'd3
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_P,
      ST_I_LO,
      ST_I_HI,
      ST_I_ACC,
      ST_I_START,
      ST_I_DIV,
      ST_D_LO,
      ST_D_HI,
      ST_D_ACC,
      ST_D_START,
      ST_D_DIV,
      ST_SUM,
      ST_MAG,
      ST_RESULT
   } state_type;

   typedef enum logic [2:0] {
      MUL_P,
      MUL_I_LO,
      MUL_I_HI,
      MUL_D_DE,
      MUL_D_LO,
      MUL_D_HI,
      MUL_E_PER
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD_HI
   } acc_op_type;

   typedef enum logic [1:0] {
      TOT_HOLD,
      TOT_LOAD_P,
      TOT_ADD_I,
      TOT_ADD_D
   } tot_op_type;

   typedef enum logic {
      DIV_SEL_I,
      DIV_SEL_D
   } div_sel_type;

   typedef struct packed {
      logic        load;
      logic        prep;
      logic        mul_en;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        hold_load;
      tot_op_type  tot_op;
      logic        div_start;
      div_sel_type div_sel;
      logic        div_step;
      logic        mag_load;
      logic        result_load;
   } cmd_type;

   typedef struct packed {
      logic div_last;
      logic out_free;
   } stat_type;

endpackage

`default_nettype wire

>>> rtl/hpid_div.sv
`timescale 1ns / 1ps
`default_nettype none

module hpid_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic                          step,
   input  wire logic [hpid_pkg::DIV_W-1:0]    dividend,
   input  wire logic [hpid_pkg::PER_W-1:0]    divisor,
   output logic      [hpid_pkg::DIV_W-1:0]    quotient,
   output logic                               last
);

   logic [hpid_pkg::DIV_W-1:0]     quo_ff, quo_in;
   logic [hpid_pkg::PER_W-1:0]     rem_ff, rem_in;
   logic [hpid_pkg::PER_W-1:0]     dsr_ff, dsr_in;
   logic [hpid_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [hpid_pkg::DIV_W-1:0]     quo_v;
   logic [hpid_pkg::PER_W-1:0]     rem_v;
   logic [hpid_pkg::PER_W:0]       trial;

   // two quotient bits per cycle while step is high
   always_comb begin
      quo_v = quo_ff;
      rem_v = rem_ff;
      trial = '0;
      for (int k = 0; k < hpid_pkg::DIV_BITS; k++) begin
         trial = {rem_v, quo_v[hpid_pkg::DIV_W-1]};
         quo_v = {quo_v[hpid_pkg::DIV_W-2:0], 1'b0};
         if (trial >= {1'b0, dsr_ff}) begin
            trial = trial - {1'b0, dsr_ff};
            quo_v[0] = 1'b1;
         end
         rem_v = trial[hpid_pkg::PER_W-1:0];
      end
   end

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      cnt_in = cnt_ff;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
         cnt_in = '0;
      end else if (step) begin
         quo_in = quo_v;
         rem_in = rem_v;
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign quotient = quo_ff;
   assign last     = (cnt_ff == hpid_pkg::DIV_LAST);

endmodule

`default_nettype wire

>>> rtl/hpid_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module hpid_dp (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [hpid_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [hpid_pkg::GAIN_W-1:0]     csr_wdata,
   input  wire logic [hpid_pkg::REQ_W-1:0]      req_tdata,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic      [hpid_pkg::RSP_W-1:0]      rsp_tdata,
   output logic                                 rsp_tuser,
   input  wire hpid_pkg::cmd_type               cmd,
   output hpid_pkg::stat_type                   stat
);

   // configuration
   logic [hpid_pkg::GAIN_W-1:0] kp_ff, kp_in, ki_ff, ki_in, kd_ff, kd_in;
   logic [hpid_pkg::VEL_W-1:0]  vmax_ff, vmax_in;

   // per-item state
   logic signed [hpid_pkg::ERR_W-1:0]   err_ff, err_in, prev_ff, prev_in;
   logic [hpid_pkg::PER_W-1:0]          per_ff, per_in;
   logic signed [hpid_pkg::INTEG_W-1:0] integ_ff, integ_in;
   logic [hpid_pkg::ERR_W-1:0]          emag_ff, emag_in;
   logic                                eneg_ff, eneg_in;
   logic [hpid_pkg::DE_W-1:0]           demag_ff, demag_in;
   logic                                deneg_ff, deneg_in;
   logic [hpid_pkg::INTEG_W-1:0]        imag_ff, imag_in;
   logic                                ineg_ff, ineg_in;
   logic [hpid_pkg::PROD_W-1:0]         prod_ff, prod_in, hold_ff, hold_in;
   logic [hpid_pkg::ACC_W-1:0]          acc_ff, acc_in;
   logic signed [hpid_pkg::TOT_W-1:0]   tot_ff, tot_in;
   logic [hpid_pkg::DMAG_W-1:0]         dmag_ff, dmag_in;
   logic                                dneg_ff, dneg_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [hpid_pkg::OUT_W-1:0]          vel_ff, vel_in;
   logic                                sat_ff, sat_in;

   // item fields
   logic signed [hpid_pkg::ANGLE_W-1:0] meas_hdg, target_hdg;
   logic [hpid_pkg::PER_W-1:0]          elapsed_us, per_sel;
   logic signed [hpid_pkg::DIFF_W-1:0]  wrap_v;

   logic                                clear_int;
   logic [hpid_pkg::INTEG_W-1:0]        integ_abs;
   logic [hpid_pkg::ERR_W-1:0]          err_abs;
   logic [hpid_pkg::DE_W-1:0]           de, de_abs;
   logic [hpid_pkg::MUL_W-1:0]          mul_a, mul_b;
   logic [hpid_pkg::PROD_W-1:0]         mul_res;
   logic [hpid_pkg::DIV_W-1:0]          quotient;
   logic [hpid_pkg::PER_W-1:0]          div_divisor;
   logic                                div_last;
   logic [hpid_pkg::TOT_W-1:0]          p_ext, q_ext, tot_abs;
   logic                                clamp;
   logic [hpid_pkg::VEL_W-1:0]          mag_out;
   logic [hpid_pkg::OUT_W-1:0]          vel_v, vel_abs;
   logic signed [hpid_pkg::INTEG_W:0]   integ_sum;
   logic [hpid_pkg::INTEG_W:0]          pe;
   logic signed [hpid_pkg::INTEG_W-1:0] integ_sat;

   assign meas_hdg   = req_tdata[16:0];
   assign target_hdg = req_tdata[33:17];
   assign elapsed_us = req_tdata[53:34];

   always_comb begin
      kp_in   = kp_ff;
      ki_in   = ki_ff;
      kd_in   = kd_ff;
      vmax_in = vmax_ff;
      if (csr_we) begin
         case (csr_index)
            hpid_pkg::CSR_KP: begin
               kp_in = csr_wdata;
            end
            hpid_pkg::CSR_KI: begin
               ki_in = csr_wdata;
            end
            hpid_pkg::CSR_KD: begin
               kd_in = csr_wdata;
            end
            hpid_pkg::CSR_VMAX: begin
               vmax_in = csr_wdata[hpid_pkg::VEL_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // heading error wrapped into half a turn either way
   always_comb begin
      wrap_v = {meas_hdg[hpid_pkg::ANGLE_W-1], meas_hdg}
             - {target_hdg[hpid_pkg::ANGLE_W-1], target_hdg};
      for (int i = 0; i < hpid_pkg::WRAP_STEPS; i++) begin
         if (wrap_v > hpid_pkg::HALF_TURN) begin
            wrap_v = wrap_v - hpid_pkg::FULL_TURN;
         end else if (wrap_v < hpid_pkg::NEG_HALF_TURN) begin
            wrap_v = wrap_v + hpid_pkg::FULL_TURN;
         end
      end
   end

   assign per_sel = (elapsed_us == '0 || elapsed_us > hpid_pkg::US_PER_S) ?
                    hpid_pkg::DEFAULT_PERIOD_US : elapsed_us;

   assign clear_int = (err_ff == '0) || (prev_ff == '0) ||
                      (err_ff[hpid_pkg::ERR_W-1] != prev_ff[hpid_pkg::ERR_W-1]);
   assign integ_abs = integ_ff[hpid_pkg::INTEG_W-1] ? ('0 - integ_ff) : integ_ff;
   assign err_abs   = err_ff[hpid_pkg::ERR_W-1] ? ('0 - err_ff) : err_ff;
   assign de        = {err_ff[hpid_pkg::ERR_W-1], err_ff} - {prev_ff[hpid_pkg::ERR_W-1], prev_ff};
   assign de_abs    = de[hpid_pkg::DE_W-1] ? ('0 - de) : de;

   // shared multiplier operand select
   always_comb begin
      case (cmd.mul_sel)
         hpid_pkg::MUL_P: begin
            mul_a = kp_ff;
            mul_b = {{(hpid_pkg::MUL_W-hpid_pkg::ERR_W){1'b0}}, emag_ff};
         end
         hpid_pkg::MUL_I_LO: begin
            mul_a = ki_ff;
            mul_b = imag_ff[hpid_pkg::MUL_W-1:0];
         end
         hpid_pkg::MUL_I_HI: begin
            mul_a = ki_ff;
            mul_b = imag_ff[hpid_pkg::INTEG_W-1:hpid_pkg::MUL_W];
         end
         hpid_pkg::MUL_D_DE: begin
            mul_a = kd_ff;
            mul_b = {{(hpid_pkg::MUL_W-hpid_pkg::DE_W){1'b0}}, demag_ff};
         end
         hpid_pkg::MUL_D_LO: begin
            mul_a = hold_ff[hpid_pkg::MUL_W-1:0];
            mul_b = {{(hpid_pkg::MUL_W-hpid_pkg::PER_W){1'b0}}, hpid_pkg::US_PER_S};
         end
         hpid_pkg::MUL_D_HI: begin
            mul_a = hold_ff[hpid_pkg::PROD_W-1:hpid_pkg::MUL_W];
            mul_b = {{(hpid_pkg::MUL_W-hpid_pkg::PER_W){1'b0}}, hpid_pkg::US_PER_S};
         end
         hpid_pkg::MUL_E_PER: begin
            mul_a = {{(hpid_pkg::MUL_W-hpid_pkg::PER_W){1'b0}}, per_ff};
            mul_b = {{(hpid_pkg::MUL_W-hpid_pkg::ERR_W){1'b0}}, emag_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_res = {{hpid_pkg::MUL_W{1'b0}}, mul_a} * {{hpid_pkg::MUL_W{1'b0}}, mul_b};

   assign div_divisor = (cmd.div_sel == hpid_pkg::DIV_SEL_I) ? hpid_pkg::US_PER_S : per_ff;

   hpid_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .step     (cmd.div_step),
      .dividend (acc_ff),
      .divisor  (div_divisor),
      .quotient (quotient),
      .last     (div_last)
   );

   assign p_ext   = {{(hpid_pkg::TOT_W-hpid_pkg::PROD_W){1'b0}}, prod_ff};
   assign q_ext   = quotient[hpid_pkg::TOT_W-1:0];
   assign tot_abs = tot_ff[hpid_pkg::TOT_W-1] ? ('0 - tot_ff) : tot_ff;

   // clamp and integral update
   assign clamp   = dmag_ff > {{(hpid_pkg::DMAG_W-hpid_pkg::VEL_W){1'b0}}, vmax_ff};
   assign mag_out = clamp ? vmax_ff : dmag_ff[hpid_pkg::VEL_W-1:0];
   assign vel_v   = dneg_ff ? ('0 - {1'b0, mag_out}) : {1'b0, mag_out};
   assign pe      = {1'b0, prod_ff};

   always_comb begin
      if (eneg_ff) begin
         integ_sum = {integ_ff[hpid_pkg::INTEG_W-1], integ_ff} - pe;
      end else begin
         integ_sum = {integ_ff[hpid_pkg::INTEG_W-1], integ_ff} + pe;
      end
      if (integ_sum[hpid_pkg::INTEG_W] != integ_sum[hpid_pkg::INTEG_W-1]) begin
         integ_sat = integ_sum[hpid_pkg::INTEG_W] ? hpid_pkg::INTEG_MIN : hpid_pkg::INTEG_MAX;
      end else begin
         integ_sat = integ_sum[hpid_pkg::INTEG_W-1:0];
      end
   end

   always_comb begin
      err_in       = err_ff;
      per_in       = per_ff;
      prev_in      = prev_ff;
      integ_in     = integ_ff;
      emag_in      = emag_ff;
      eneg_in      = eneg_ff;
      demag_in     = demag_ff;
      deneg_in     = deneg_ff;
      imag_in      = imag_ff;
      ineg_in      = ineg_ff;
      prod_in      = cmd.mul_en ? mul_res : prod_ff;
      hold_in      = cmd.hold_load ? prod_ff : hold_ff;
      acc_in       = acc_ff;
      tot_in       = tot_ff;
      dmag_in      = dmag_ff;
      dneg_in      = dneg_ff;
      vel_in       = vel_ff;
      sat_in       = sat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      if (cmd.load) begin
         err_in = wrap_v[hpid_pkg::ERR_W-1:0];
         per_in = per_sel;
      end

      if (cmd.prep) begin
         emag_in  = err_abs;
         eneg_in  = err_ff[hpid_pkg::ERR_W-1];
         demag_in = de_abs;
         deneg_in = de[hpid_pkg::DE_W-1];
         if (clear_int) begin
            integ_in = '0;
            imag_in  = '0;
            ineg_in  = 1'b0;
         end else begin
            imag_in = integ_abs;
            ineg_in = integ_ff[hpid_pkg::INTEG_W-1];
         end
      end

      case (cmd.acc_op)
         hpid_pkg::ACC_LOAD: begin
            acc_in = {{hpid_pkg::MUL_W{1'b0}}, prod_ff};
         end
         hpid_pkg::ACC_ADD_HI: begin
            acc_in = acc_ff + {prod_ff, {hpid_pkg::MUL_W{1'b0}}};
         end
         default: begin
         end
      endcase

      case (cmd.tot_op)
         hpid_pkg::TOT_LOAD_P: begin
            tot_in = eneg_ff ? ('0 - p_ext) : p_ext;
         end
         hpid_pkg::TOT_ADD_I: begin
            tot_in = ineg_ff ? (tot_ff - q_ext) : (tot_ff + q_ext);
         end
         hpid_pkg::TOT_ADD_D: begin
            tot_in = deneg_ff ? (tot_ff - q_ext) : (tot_ff + q_ext);
         end
         default: begin
         end
      endcase

      if (cmd.mag_load) begin
         dmag_in = tot_abs[hpid_pkg::TOT_W-1:hpid_pkg::FRAC_BITS];
         dneg_in = tot_ff[hpid_pkg::TOT_W-1];
      end

      if (cmd.result_load) begin
         vel_in       = vel_v;
         sat_in       = clamp;
         prev_in      = err_ff;
         rsp_valid_in = 1'b1;
         if (!clamp) begin
            integ_in = integ_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff        <= '0;
         ki_ff        <= '0;
         kd_ff        <= '0;
         vmax_ff      <= '0;
         prev_ff      <= '0;
         integ_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         kp_ff        <= kp_in;
         ki_ff        <= ki_in;
         kd_ff        <= kd_in;
         vmax_ff      <= vmax_in;
         prev_ff      <= prev_in;
         integ_ff     <= integ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff   <= err_in;
      per_ff   <= per_in;
      emag_ff  <= emag_in;
      eneg_ff  <= eneg_in;
      demag_ff <= demag_in;
      deneg_ff <= deneg_in;
      imag_ff  <= imag_in;
      ineg_ff  <= ineg_in;
      prod_ff  <= prod_in;
      hold_ff  <= hold_in;
      acc_ff   <= acc_in;
      tot_ff   <= tot_in;
      dmag_ff  <= dmag_in;
      dneg_ff  <= dneg_in;
      vel_ff   <= vel_in;
      sat_ff   <= sat_in;
   end

   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_tdata     = {{(hpid_pkg::RSP_W-hpid_pkg::OUT_W){1'b0}}, vel_ff};
   assign rsp_tuser     = sat_ff;
   assign stat.div_last = div_last;
   assign stat.out_free = !rsp_valid_ff || rsp_tready;

   assign vel_abs = vel_ff[hpid_pkg::OUT_W-1] ? ('0 - vel_ff) : vel_ff;

   a_result_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.result_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result written over an item not yet taken");

   a_clamp_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (vel_abs <= {1'b0, vmax_ff}) &&
                       (!sat_ff || vel_abs == {1'b0, vmax_ff}))
      else $error("drive outside clamp or flagged clamp off the limit");

   a_integ_hold: assert property (@(posedge clock) disable iff (reset)
      !cmd.prep && !cmd.result_load |=> $stable(integ_ff))
      else $error("integral changed outside clear or update");

endmodule

`default_nettype wire

>>> rtl/hpid_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module hpid_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire hpid_pkg::stat_type  stat,
   output hpid_pkg::cmd_type        cmd
);

   hpid_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hpid_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_tready  = 1'b0;
      cmd         = '0;
      cmd.mul_sel = hpid_pkg::MUL_P;
      cmd.acc_op  = hpid_pkg::ACC_HOLD;
      cmd.tot_op  = hpid_pkg::TOT_HOLD;
      cmd.div_sel = hpid_pkg::DIV_SEL_I;
      case (state_ff)
         hpid_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = hpid_pkg::ST_PREP;
            end
         end
         hpid_pkg::ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = hpid_pkg::ST_P;
         end
         hpid_pkg::ST_P: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = hpid_pkg::MUL_P;
            state_in    = hpid_pkg::ST_I_LO;
         end
         hpid_pkg::ST_I_LO: begin
            cmd.tot_op  = hpid_pkg::TOT_LOAD_P;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = hpid_pkg::MUL_I_LO;
            state_in    = hpid_pkg::ST_I_HI;
         end
         hpid_pkg::ST_I_HI: begin
            cmd.acc_op  = hpid_pkg::ACC_LOAD;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = hpid_pkg::MUL_I_HI;
            state_in    = hpid_pkg::ST_I_ACC;
         end
         hpid_pkg::ST_I_ACC: begin
            cmd.acc_op  = hpid_pkg::ACC_ADD_HI;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = hpid_pkg::MUL_D_DE;
            state_in    = hpid_pkg::ST_I_START;
         end
         hpid_pkg::ST_I_START: begin
            cmd.hold_load = 1'b1;
            cmd.div_start = 1'b1;
            cmd.div_sel   = hpid_pkg::DIV_SEL_I;
            state_in      = hpid_pkg::ST_I_DIV;
         end
         hpid_pkg::ST_I_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = hpid_pkg::ST_D_LO;
            end
         end
         hpid_pkg::ST_D_LO: begin
            cmd.tot_op  = hpid_pkg::TOT_ADD_I;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = hpid_pkg::MUL_D_LO;
            state_in    = hpid_pkg::ST_D_HI;
         end
         hpid_pkg::ST_D_HI: begin
            cmd.acc_op  = hpid_pkg::ACC_LOAD;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = hpid_pkg::MUL_D_HI;
            state_in    = hpid_pkg::ST_D_ACC;
         end
         hpid_pkg::ST_D_ACC: begin
            cmd.acc_op  = hpid_pkg::ACC_ADD_HI;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = hpid_pkg::MUL_E_PER;
            state_in    = hpid_pkg::ST_D_START;
         end
         hpid_pkg::ST_D_START: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = hpid_pkg::DIV_SEL_D;
            state_in      = hpid_pkg::ST_D_DIV;
         end
         hpid_pkg::ST_D_DIV: begin
            cmd.div_step = 1'b1;
            cmd.div_sel  = hpid_pkg::DIV_SEL_D;
            if (stat.div_last) begin
               state_in = hpid_pkg::ST_SUM;
            end
         end
         hpid_pkg::ST_SUM: begin
            cmd.tot_op = hpid_pkg::TOT_ADD_D;
            state_in   = hpid_pkg::ST_MAG;
         end
         hpid_pkg::ST_MAG: begin
            cmd.mag_load = 1'b1;
            state_in     = hpid_pkg::ST_RESULT;
         end
         hpid_pkg::ST_RESULT: begin
            if (stat.out_free) begin
               cmd.result_load = 1'b1;
               state_in        = hpid_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hpid_pkg::ST_IDLE;
         end
      endcase
   end

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item taken while one is in work");

   a_ready_after_result: assert property (@(posedge clock) disable iff (reset)
      $rose(req_tready) |-> $past(cmd.result_load) || $past(reset))
      else $error("input reopened without a result");

endmodule

`default_nettype wire

>>> rtl/heading_pid_with_antiwindup.sv
// heading pid controller with conditional-integration anti-windup
//
// req channel: one item per sample (measured heading, target heading and
// elapsed microseconds); rsp channel: one item per sample with the clamped
// drive in tdata and the clamp flag in tuser. csr port writes kp, ki, kd and
// the clamp magnitude by index; the user must do so only while no item is in
// work, as the block itself does not enforce it.
//
// one item at a time: the input is not ready again until the item's result
// is written. the shared radix-4 divider makes two passes (integral term,
// then derivative term), and the 24x24 multiplier runs in the states around
// them.
//
// reset clears the gains, the clamp, the stored error and the integral,
// and leaves rsp_tvalid low. a finished result waits in the output
// register while the receiver stalls; the next item can be accepted and
// worked on meanwhile, and only its result write waits for the slot.
`timescale 1ns / 1ps
`default_nettype none

module heading_pid_with_antiwindup (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // meas_hdg[16:0], target_hdg[33:17], elapsed_us[53:34], zero fill
   input  wire logic [hpid_pkg::REQ_W-1:0]      req_tdata,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // turn_rate[16:0], zero fill
   output logic      [hpid_pkg::RSP_W-1:0]      rsp_tdata,
   // saturated[0]
   output logic                                 rsp_tuser,
   input  wire logic                            csr_we,
   input  wire logic [hpid_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [hpid_pkg::GAIN_W-1:0]     csr_wdata
);

   hpid_pkg::cmd_type  cmd;
   hpid_pkg::stat_type stat;

   hpid_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   hpid_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int PHASES = 13;
   localparam int PHASE_ITEMS = 150;
   localparam int HOLD_CYCLES = 1500;
   localparam int HOLD_AT = 400;
   localparam int DIR_N = 24;

   localparam longint WRAP_HALF = 23040;
   localparam longint WRAP_FULL = 46080;
   localparam longint USEC = 1000000;
   localparam longint DEFAULT_US = 33330;
   localparam longint INTEG_TOP = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint INTEG_BOT = -INTEG_TOP - 1;
   localparam int FRAC = 23;

   typedef struct packed {
      logic [16:0] vel;
      logic        sat;
   } drive_type;

   typedef struct packed {
      bit        setcfg;
      bit [23:0] kp;
      bit [23:0] ki;
      bit [23:0] kd;
      bit [15:0] vmax;
      int        robot;
      int        target;
      int        elapsed;
      bit        typed;
      int        vel;
      bit        sat;
   } dir_row_type;

   logic                              clock;
   logic                              reset;
   logic                              req_tvalid;
   logic                              req_tready;
   logic [hpid_pkg::REQ_W-1:0]        req_tdata;
   logic                              rsp_tvalid;
   logic                              rsp_tready;
   logic [hpid_pkg::RSP_W-1:0]        rsp_tdata;
   logic                              rsp_tuser;
   logic                              csr_we;
   logic [hpid_pkg::CSR_IDX_W-1:0]    csr_index;
   logic [hpid_pkg::GAIN_W-1:0]       csr_wdata;

   // controller copy
   longint gain_p, gain_i, gain_d, vel_limit;
   longint hdg_prev_err, hdg_integral;

   drive_type drive_q[$];
   int        mismatches;
   int        results_seen;
   bit        steady;

   dir_row_type dir_rows [0:DIR_N-1] = '{
      // reset values: every drive is zero
      '{1'b0, 24'h0, 24'h0, 24'h0, 16'h0, 0, 0, 0, 1'b1, 0, 1'b0},
      '{1'b0, 24'h0, 24'h0, 24'h0, 16'h0, -65536, 65535, 1048575, 1'b1, 0, 1'b0},
      '{1'b0, 24'h0, 24'h0, 24'h0, 16'h0, 65535, -65536, 1000000, 1'b1, 0, 1'b0},
      '{1'b0, 24'h0, 24'h0, 24'h0, 16'h0, 46080, -46080, 1, 1'b1, 0, 1'b0},
      '{1'b0, 24'h0, 24'h0, 24'h0, 16'h0, -46080, 46080, 1000001, 1'b1, 0, 1'b0},
      '{1'b0, 24'h0, 24'h0, 24'h0, 16'h0, 23040, 0, 33330, 1'b1, 0, 1'b0},
      // zero clamp
      '{1'b1, 24'hFFFFFF, 24'h0, 24'h0, 16'h0, 100, 0, 500, 1'b1, 0, 1'b1},
      '{1'b0, 24'h0, 24'h0, 24'h0, 16'h0, 0, 100, 500, 1'b1, 0, 1'b1},
      '{1'b0, 24'h0, 24'h0, 24'h0, 16'h0, 5, 5, 500, 1'b1, 0, 1'b0},
      '{1'b0, 24'h0, 24'h0, 24'h0, 16'h0, 23041, 0, 500, 1'b1, 0, 1'b1},
      // unit gain: drive equals the wrapped error
      '{1'b1, 24'h800000, 24'h0, 24'h0, 16'hFFFF, 23040, 0, 1000, 1'b1, 23040, 1'b0},
      '{1'b0, 24'h0, 24'h0, 24'h0, 16'h0, 0, 23040, 1000, 1'b1, -23040, 1'b0},
      '{1'b0, 24'h0, 24'h0, 24'h0, 16'h0, 23041, 0, 1000, 1'b1, -23039, 1'b0},
      '{1'b0, 24'h0, 24'h0, 24'h0, 16'h0, -23041, 0, 1000, 1'b1, 23039, 1'b0},
      '{1'b0, 24'h0, 24'h0, 24'h0, 16'h0, -1, 0, 1000, 1'b1, -1, 1'b0},
      // clamp edge
      '{1'b1, 24'h800000, 24'h0, 24'h0, 16'd100, 100, 0, 1000, 1'b1, 100, 1'b0},
      '{1'b0, 24'h0, 24'h0, 24'h0, 16'h0, 101, 0, 1000, 1'b1, 100, 1'b1},
      '{1'b0, 24'h0, 24'h0, 24'h0, 16'h0, -100, 0, 1000, 1'b1, -100, 1'b0},
      '{1'b0, 24'h0, 24'h0, 24'h0, 16'h0, 0, 101, 1000, 1'b1, -100, 1'b1},
      // all three terms, default period, sign change
      '{1'b1, 24'h010000, 24'h020000, 24'h008000, 16'hFFFF, 300, 0, 20000, 1'b0, 0, 1'b0},
      '{1'b0, 24'h0, 24'h0, 24'h0, 16'h0, 400, 0, 0, 1'b0, 0, 1'b0},
      '{1'b0, 24'h0, 24'h0, 24'h0, 16'h0, 500, 0, 1000000, 1'b0, 0, 1'b0},
      '{1'b0, 24'h0, 24'h0, 24'h0, 16'h0, -200, 0, 30000, 1'b0, 0, 1'b0},
      '{1'b0, 24'h0, 24'h0, 24'h0, 16'h0, -200, 0, 1048575, 1'b0, 0, 1'b0}
   };

   heading_pid_with_antiwindup i_dut (.*);

   function automatic drive_type pid_drive(logic signed [16:0] meas, logic signed [16:0] targ,
                                           logic [19:0] elapsed);
      longint    err, diff, pterm, iterm, dterm, total, drive, acc;
      bit [63:0] per, imag, dmag;
      drive_type res;
      err = longint'(meas) - longint'(targ);
      while (err > WRAP_HALF) err -= WRAP_FULL;
      while (err < -WRAP_HALF) err += WRAP_FULL;
      per = 64'(elapsed);
      if (per == 0 || per > USEC) per = DEFAULT_US;
      pterm = gain_p * err;
      if (err * hdg_prev_err <= 0) hdg_integral = 0;
      imag = (hdg_integral < 0) ? 64'(-hdg_integral) : 64'(hdg_integral);
      iterm = longint'(64'(gain_i) * (imag / USEC) + (64'(gain_i) * (imag % USEC)) / USEC);
      if (hdg_integral < 0) iterm = -iterm;
      diff = err - hdg_prev_err;
      dmag = (64'(gain_d) * ((diff < 0) ? 64'(-diff) : 64'(diff)) * USEC) / per;
      dterm = (diff < 0) ? -longint'(dmag) : longint'(dmag);
      total = pterm + iterm + dterm;
      drive = (total < 0) ? -((-total) >> FRAC) : (total >> FRAC);
      res.sat = 1'b1;
      if (drive > vel_limit) begin
         drive = vel_limit;
      end else if (drive < -vel_limit) begin
         drive = -vel_limit;
      end else begin
         res.sat = 1'b0;
         acc = hdg_integral + err * longint'(per);
         if (acc > INTEG_TOP) acc = INTEG_TOP;
         if (acc < INTEG_BOT) acc = INTEG_BOT;
         hdg_integral = acc;
      end
      hdg_prev_err = err;
      res.vel = drive[16:0];
      return res;
   endfunction

   function automatic bit [23:0] pick_gain();
      case ($urandom_range(0, 5))
         0: return 24'h0;
         1: return 24'hFFFFFF;
         2: return 24'($urandom);
         default: return 24'($urandom_range(0, 24'h03FFFF));
      endcase
   endfunction

   function automatic int pick_period();
      case ($urandom_range(0, 15))
         0: return 0;
         1: return 1000000;
         2: return int'($urandom_range(1000001, 20'hFFFFF));
         3: return int'($urandom_range(1, 20'hFFFFF));
         default: return int'($urandom_range(1000, 100000));
      endcase
   endfunction

   // called at a falling edge with csr_we low and nothing in work
   task automatic load_gains(bit [23:0] kp, bit [23:0] ki, bit [23:0] kd, bit [23:0] vmax);
      csr_we <= 1'b1;
      csr_index <= hpid_pkg::CSR_KP;
      csr_wdata <= kp;
      @(negedge clock);
      csr_index <= hpid_pkg::CSR_KI;
      csr_wdata <= ki;
      @(negedge clock);
      csr_index <= hpid_pkg::CSR_KD;
      csr_wdata <= kd;
      @(negedge clock);
      csr_index <= hpid_pkg::CSR_VMAX;
      csr_wdata <= vmax;
      @(negedge clock);
      csr_we <= 1'b0;
      gain_p = longint'(kp);
      gain_i = longint'(ki);
      gain_d = longint'(kd);
      vel_limit = longint'(vmax[15:0]);
   endtask

   // starts and ends at a falling edge; valid stays high when no gap is drawn
   task automatic send_sample(int robot, int target, int elapsed, bit typed, int tvel,
                              bit tsat);
      int                         gap;
      logic [hpid_pkg::REQ_W-1:0] word;
      drive_type                  d;
      gap = steady ? 0 : int'($urandom_range(0, 10));
      word = '0;
      word[16:0] = robot[16:0];
      word[33:17] = target[16:0];
      word[53:34] = elapsed[19:0];
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= word;
      do @(posedge clock); while (!req_tready);
      d = pid_drive(word[16:0], word[33:17], word[53:34]);
      if (typed) begin
         d.vel = tvel[16:0];
         d.sat = tsat;
      end
      drive_q.push_back(d);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (drive_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("TEST FAILED");
      $finish;
   end

   // result side
   initial begin
      drive_type want;
      int        stall;
      bit        held;
      rsp_tready = 1'b0;
      results_seen = 0;
      held = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = steady ? 0 : int'($urandom_range(0, 10));
         if (!held && results_seen >= HOLD_AT) begin
            stall = HOLD_CYCLES;
            held = 1'b1;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         results_seen++;
         if (drive_q.size() == 0) begin
            $display("%0t unexpected item: turn_rate %0d saturated %0b", $time,
                     $signed(rsp_tdata[16:0]), rsp_tuser);
            mismatches++;
         end else begin
            want = drive_q.pop_front();
            if (rsp_tdata[16:0] !== want.vel) begin
               $display("%0t turn_rate mismatch: expected %0d got %0d", $time,
                        $signed(want.vel), $signed(rsp_tdata[16:0]));
               mismatches++;
            end
            if (rsp_tuser !== want.sat) begin
               $display("%0t saturated mismatch: expected %0b got %0b", $time,
                        want.sat, rsp_tuser);
               mismatches++;
            end
         end
         @(negedge clock);
      end
   end

   // stimulus
   initial begin
      int row, ph, n, kind, robot_a, ref_a;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_index = hpid_pkg::CSR_KP;
      csr_wdata = '0;
      steady = 1'b0;
      mismatches = 0;
      gain_p = 0;
      gain_i = 0;
      gain_d = 0;
      vel_limit = 0;
      hdg_prev_err = 0;
      hdg_integral = 0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (row = 0; row < DIR_N; row++) begin
         if (dir_rows[row].setcfg) begin
            drain();
            load_gains(dir_rows[row].kp, dir_rows[row].ki, dir_rows[row].kd,
                       {8'h0, dir_rows[row].vmax});
         end
         send_sample(dir_rows[row].robot, dir_rows[row].target, dir_rows[row].elapsed,
                     dir_rows[row].typed, dir_rows[row].vel, dir_rows[row].sat);
      end

      robot_a = 0;
      ref_a = 0;
      for (ph = 0; ph < PHASES; ph++) begin
         drain();
         if (ph == 0) begin
            load_gains(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
         end else if (ph == 1) begin
            load_gains(pick_gain(), pick_gain(), pick_gain(), {8'($urandom), 16'h0});
         end else begin
            case ($urandom_range(0, 5))
               0: load_gains(pick_gain(), pick_gain(), pick_gain(), {8'($urandom), 16'h0});
               1: load_gains(pick_gain(), pick_gain(), pick_gain(),
                             {8'($urandom), 16'hFFFF});
               default: load_gains(pick_gain(), pick_gain(), pick_gain(),
                                   {8'($urandom), 16'($urandom_range(1, 2000))});
            endcase
         end
         steady = (ph == 2) || ($urandom_range(0, 4) == 0);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            kind = int'($urandom_range(0, 19));
            if (kind < 2) begin
               send_sample(int'($urandom), int'($urandom), int'($urandom), 1'b0, 0, 1'b0);
            end else begin
               if (kind == 2) begin
                  ref_a = int'($urandom_range(0, 92160)) - 46080;
               end else if (kind == 3) begin
                  ref_a = int'($urandom_range(0, 92160)) - 46080;
                  robot_a = ref_a + int'($urandom_range(0, 4000)) - 2000;
               end else begin
                  robot_a = robot_a + int'($urandom_range(0, 60)) - 30;
               end
               if (robot_a > 65535) robot_a = 65535;
               if (robot_a < -65536) robot_a = -65536;
               send_sample(robot_a, ref_a, pick_period(), 1'b0, 0, 1'b0);
            end
         end
      end

      drain();
      repeat (100) @(negedge clock);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
